/* rtl/dtif_pkg.sv */
package dtif_pkg;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_WRITE = 2'd2
    } func_e;

    localparam logic [15:0] ADDR_DIV  = 16'hff04;
    localparam logic [15:0] ADDR_TIMA = 16'hff05;
    localparam logic [15:0] ADDR_TMA  = 16'hff06;
    localparam logic [15:0] ADDR_TAC  = 16'hff07;
    localparam logic [15:0] ADDR_IF   = 16'hff0f;
    localparam logic [15:0] ADDR_IE   = 16'hffff;

    localparam int unsigned TICK_W   = 10;
    localparam int unsigned TAC_W    = 3;
    localparam logic [2:0]  TAC_MASK = 3'h7;

    // Timer select codes in the low bits of TAC.
    localparam logic [1:0] TAC_SEL_1024 = 2'd0;
    localparam logic [1:0] TAC_SEL_16   = 2'd1;
    localparam logic [1:0] TAC_SEL_64   = 2'd2;
    localparam logic [1:0] TAC_SEL_256  = 2'd3;

    localparam logic [TICK_W-1:0] MASK_1024 = TICK_W'(1024 - 1);
    localparam logic [TICK_W-1:0] MASK_16   = TICK_W'(16 - 1);
    localparam logic [TICK_W-1:0] MASK_64   = TICK_W'(64 - 1);
    localparam logic [TICK_W-1:0] MASK_256  = TICK_W'(256 - 1);

    localparam int unsigned IRQ_TIMER_BIT = 2;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] address;
        logic [7:0]  write_data;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       address_hit;
        logic       timer_irq_flag;
    } rsp_t;

endpackage

/* rtl/dtif_core.sv */
module dtif_core
    import dtif_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic fire,
    input  req_t item,
    output rsp_t result
);

    logic [TICK_W-1:0] tick_counter_reg, tick_counter_next;
    logic [7:0]        divider_reg, divider_next;
    logic [7:0]        timer_count_reg, timer_count_next;
    logic [7:0]        timer_reload_reg, timer_reload_next;
    logic [TAC_W-1:0]  timer_control_reg, timer_control_next;
    logic [7:0]        irq_flags_reg, irq_flags_next;
    logic [7:0]        irq_enables_reg, irq_enables_next;

    logic [TICK_W-1:0] period_mask;
    logic              timer_step;
    logic              is_tick;
    logic [7:0]        rdata;
    logic              hit;

    assign is_tick = (item.func == FUNC_TICK);

    always_comb
    begin
        unique case (timer_control_reg[1:0])
            TAC_SEL_1024: period_mask = MASK_1024;
            TAC_SEL_16:   period_mask = MASK_16;
            TAC_SEL_64:   period_mask = MASK_64;
            TAC_SEL_256:  period_mask = MASK_256;
            default:      period_mask = MASK_1024;
        endcase
    end

    assign timer_step = timer_control_reg[2] && ((tick_counter_reg & period_mask) == '0);

    always_comb
    begin
        tick_counter_next  = tick_counter_reg;
        divider_next       = divider_reg;
        timer_count_next   = timer_count_reg;
        timer_reload_next  = timer_reload_reg;
        timer_control_next = timer_control_reg;
        irq_flags_next     = irq_flags_reg;
        irq_enables_next   = irq_enables_reg;
        rdata              = '0;
        hit                = 1'b0;

        unique case (item.func)
            FUNC_TICK:
            begin
                if (tick_counter_reg[7:0] == 8'h00)
                begin
                    divider_next = divider_reg + 8'd1;
                end
                if (timer_step)
                begin
                    if (timer_count_reg == 8'hff)
                    begin
                        timer_count_next              = timer_reload_reg;
                        irq_flags_next[IRQ_TIMER_BIT] = 1'b1;
                    end
                    else
                    begin
                        timer_count_next = timer_count_reg + 8'd1;
                    end
                end
                tick_counter_next = tick_counter_reg + TICK_W'(1);
            end
            FUNC_READ:
            begin
                hit = 1'b1;
                unique case (item.address)
                    ADDR_DIV:  rdata = divider_reg;
                    ADDR_TIMA: rdata = timer_count_reg;
                    ADDR_TMA:  rdata = timer_reload_reg;
                    ADDR_TAC:  rdata = {5'd0, timer_control_reg};
                    ADDR_IF:   rdata = irq_flags_reg;
                    ADDR_IE:   rdata = irq_enables_reg;
                    default:   hit   = 1'b0;
                endcase
            end
            FUNC_WRITE:
            begin
                hit = 1'b1;
                unique case (item.address)
                    ADDR_DIV:  divider_next       = item.write_data;
                    ADDR_TIMA: timer_count_next   = item.write_data;
                    ADDR_TMA:  timer_reload_next  = item.write_data;
                    ADDR_TAC:  timer_control_next = item.write_data[2:0] & TAC_MASK;
                    ADDR_IF:   irq_flags_next     = item.write_data;
                    ADDR_IE:   irq_enables_next   = item.write_data;
                    default:   hit                = 1'b0;
                endcase
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

    // The flag reported is the one left behind after this word is applied.
    assign result.read_data      = rdata;
    assign result.address_hit    = hit;
    assign result.timer_irq_flag = irq_flags_next[IRQ_TIMER_BIT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_counter_reg  <= '0;
            divider_reg       <= '0;
            timer_count_reg   <= '0;
            timer_reload_reg  <= '0;
            timer_control_reg <= '0;
            irq_flags_reg     <= '0;
            irq_enables_reg   <= '0;
        end
        else if (fire)
        begin
            tick_counter_reg  <= tick_counter_next;
            divider_reg       <= divider_next;
            timer_count_reg   <= timer_count_next;
            timer_reload_reg  <= timer_reload_next;
            timer_control_reg <= timer_control_next;
            irq_flags_reg     <= irq_flags_next;
            irq_enables_reg   <= irq_enables_next;
        end
    end

    a_idle_holds_counter: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(tick_counter_reg))
        else $error("tick counter moved without a word");

    a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_tick |=> tick_counter_reg == $past(tick_counter_reg) + TICK_W'(1))
        else $error("tick counter did not advance on a tick");

    a_timer_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_tick && !timer_control_reg[2] |=> $stable(timer_count_reg))
        else $error("timer counted while disabled");

    a_overflow_irq: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_tick && timer_step && timer_count_reg == 8'hff
        |=> irq_flags_reg[IRQ_TIMER_BIT] && timer_count_reg == $past(timer_reload_reg))
        else $error("timer overflow did not reload and raise the flag");

endmodule

/* rtl/divider_timer_with_irq_flags_top.sv */
// Channel   Direction  Handshake              Word
// req       in         req_valid / req_stall  func, address, write_data
// rsp       out        rsp_valid / rsp_stall  read_data, address_hit, timer_irq_flag
//
// One word is accepted per cycle while req_stall is low; each result becomes valid once its word
// has passed through the input register and then the result register around the core.
// Reset is asynchronous and active low; it clears all timer state and valid bits.
// A stall on rsp holds the result register and, once the input register is also
// full, raises req_stall in the same cycle.
module divider_timer_with_irq_flags_top
    import dtif_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic stage_valid_reg;
    req_t stage_reg;
    logic rsp_valid_reg;
    rsp_t rsp_reg;

    logic advance;
    logic req_fire;
    logic core_fire;
    rsp_t core_result;

    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign req_stall = stage_valid_reg && !advance;
    assign req_fire  = req_valid && !req_stall;
    assign core_fire = stage_valid_reg && advance;

    dtif_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (core_fire),
        .item   (stage_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (!stage_valid_reg || advance)
            begin
                stage_valid_reg <= req_valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= stage_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            stage_reg <= req;
        end
        if (core_fire)
        begin
            rsp_reg <= core_result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* verif/dtif_rsp_checker.sv */
`timescale 1ns / 1ps

module dtif_rsp_checker
    import dtif_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_stall,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp,
    output int   failures,
    output int   pending
);

    logic [TICK_W-1:0] tick_cnt;
    logic [7:0]        div_q;
    logic [7:0]        tima_q;
    logic [7:0]        tma_q;
    logic [TAC_W-1:0]  tac_q;
    logic [7:0]        if_q;
    logic [7:0]        ie_q;

    rsp_t expected_rsp[$];
    int   fail_cnt;

    // Applies one word to the timer state and returns the word it should produce.
    function automatic rsp_t predict_timer_rsp(input req_t w);
        rsp_t r;
        logic [TICK_W-1:0] rate_mask;
        r = '0;
        rate_mask = MASK_1024;
        case (w.func)
            FUNC_TICK: begin
                if (tick_cnt[7:0] == 8'd0)
                    div_q = div_q + 8'd1;
                if (tac_q[2]) begin
                    case (tac_q[1:0])
                        TAC_SEL_1024: rate_mask = MASK_1024;
                        TAC_SEL_16:   rate_mask = MASK_16;
                        TAC_SEL_64:   rate_mask = MASK_64;
                        TAC_SEL_256:  rate_mask = MASK_256;
                    endcase
                    if ((tick_cnt & rate_mask) == '0) begin
                        if (tima_q == 8'hff) begin
                            tima_q = tma_q;
                            if_q[IRQ_TIMER_BIT] = 1'b1;
                        end
                        else
                        begin
                            tima_q = tima_q + 8'd1;
                        end
                    end
                end
                tick_cnt = tick_cnt + 1'b1;
            end
            FUNC_READ: begin
                r.address_hit = 1'b1;
                case (w.address)
                    ADDR_DIV:  r.read_data = div_q;
                    ADDR_TIMA: r.read_data = tima_q;
                    ADDR_TMA:  r.read_data = tma_q;
                    ADDR_TAC:  r.read_data = 8'(tac_q);
                    ADDR_IF:   r.read_data = if_q;
                    ADDR_IE:   r.read_data = ie_q;
                    default:   r.address_hit = 1'b0;
                endcase
            end
            FUNC_WRITE: begin
                r.address_hit = 1'b1;
                case (w.address)
                    ADDR_DIV:  div_q = w.write_data;
                    ADDR_TIMA: tima_q = w.write_data;
                    ADDR_TMA:  tma_q = w.write_data;
                    ADDR_TAC:  tac_q = w.write_data[TAC_W-1:0] & TAC_MASK;
                    ADDR_IF:   if_q = w.write_data;
                    ADDR_IE:   ie_q = w.write_data;
                    default:   r.address_hit = 1'b0;
                endcase
            end
            default: ;
        endcase
        r.timer_irq_flag = if_q[IRQ_TIMER_BIT];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t exp_w;
        if (!rst_n) begin
            tick_cnt = '0;
            div_q = '0;
            tima_q = '0;
            tma_q = '0;
            tac_q = '0;
            if_q = '0;
            ie_q = '0;
            expected_rsp.delete();
            fail_cnt = 0;
            failures <= 0;
            pending <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall) begin
                if (expected_rsp.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected result word: read_data=%0h hit=%0b irq=%0b",
                                 rsp.read_data, rsp.address_hit, rsp.timer_irq_flag);
                end
                else
                begin
                    exp_w = expected_rsp.pop_front();
                    if (rsp.read_data !== exp_w.read_data ||
                        rsp.address_hit !== exp_w.address_hit ||
                        rsp.timer_irq_flag !== exp_w.timer_irq_flag) begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display({"mismatch: expected read_data=%0h hit=%0b irq=%0b,",
                                      " got read_data=%0h hit=%0b irq=%0b"},
                                     exp_w.read_data, exp_w.address_hit,
                                     exp_w.timer_irq_flag, rsp.read_data,
                                     rsp.address_hit, rsp.timer_irq_flag);
                    end
                end
            end
            if (req_valid && !req_stall)
                expected_rsp.push_back(predict_timer_rsp(req));
            failures <= fail_cnt;
            pending <= expected_rsp.size();
        end
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
    import dtif_pkg::*;

    localparam logic [1:0] FUNC_RSVD = 2'd3;
    localparam int IDLE_LIMIT = 1000;
    localparam int WORD_TARGET = 1650;

    logic clk;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    int fail_count;
    int pending_count;
    int words_sent = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit no_idle = 1'b0;
    bit drained = 1'b0;

    divider_timer_with_irq_flags_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    dtif_rsp_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .failures  (fail_count),
        .pending   (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: after each taken word, stall for a freshly drawn number of cycles.
    always @(posedge clk)
    begin
        if (rsp_valid && !rsp_stall)
            stall_left = no_idle ? 0 : $urandom_range(0, 19);
        else if (stall_left > 0)
            stall_left--;
        rsp_stall <= (stall_left > 0);
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("divider_timer_with_irq_flags_top regression: fail");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [1:0] f, input logic [15:0] a, input logic [7:0] d);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= '{func: f, address: a, write_data: d};
        @(posedge clk);
        while (req_stall) @(posedge clk);
        words_sent++;
    endtask

    task automatic wait_all_results();
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
    endtask

    function automatic logic [15:0] mapped_addr();
        case ($urandom_range(0, 5))
            0: return ADDR_DIV;
            1: return ADDR_TIMA;
            2: return ADDR_TMA;
            3: return ADDR_TAC;
            4: return ADDR_IF;
            default: return ADDR_IE;
        endcase
    endfunction

    task automatic send_random_word();
        int pick;
        logic [15:0] a;
        logic [7:0] d;
        pick = $urandom_range(0, 99);
        a = 16'($urandom);
        d = 8'($urandom);
        if (pick < 50)
            send_word(FUNC_TICK, a, d);
        else if (pick < 70)
            send_word(FUNC_READ, mapped_addr(), d);
        else if (pick < 85)
            send_word(FUNC_WRITE, mapped_addr(), d);
        else if (pick < 95)
            send_word($urandom_range(0, 1) ? FUNC_READ : FUNC_WRITE, a, d);
        else
            send_word(FUNC_RSVD, $urandom_range(0, 1) ? mapped_addr() : a, d);
    endtask

    // Arms the timer near overflow and sends a random run of ticks, with occasional reads, so that it can reload.
    task automatic run_timer_burst();
        int ticks;
        send_word(FUNC_WRITE, ADDR_TAC, 8'($urandom) | 8'h04);
        send_word(FUNC_WRITE, ADDR_TMA, 8'($urandom));
        send_word(FUNC_WRITE, ADDR_TIMA, 8'($urandom_range(240, 255)));
        ticks = $urandom_range(16, 80);
        repeat (ticks) begin
            if ($urandom_range(0, 9) == 0)
                send_word(FUNC_READ, mapped_addr(), 8'($urandom));
            else
                send_word(FUNC_TICK, 16'($urandom), 8'($urandom));
        end
        send_word(FUNC_READ, ADDR_TIMA, 8'($urandom));
        send_word(FUNC_READ, ADDR_IF, 8'($urandom));
        if ($urandom_range(0, 1))
            send_word(FUNC_WRITE, ADDR_IF, 8'($urandom) & 8'hfb);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values of every mapped register.
        send_word(FUNC_READ, ADDR_DIV, 8'h00);
        send_word(FUNC_READ, ADDR_TIMA, 8'h00);
        send_word(FUNC_READ, ADDR_TMA, 8'h00);
        send_word(FUNC_READ, ADDR_TAC, 8'h00);
        send_word(FUNC_READ, ADDR_IF, 8'h00);
        send_word(FUNC_READ, ADDR_IE, 8'hff);
        send_word(FUNC_WRITE, ADDR_IE, 8'hff);
        send_word(FUNC_WRITE, ADDR_TMA, 8'hab);
        // Only the low three control bits are kept.
        send_word(FUNC_WRITE, ADDR_TAC, 8'hff);
        send_word(FUNC_READ, ADDR_TAC, 8'h00);
        send_word(FUNC_WRITE, ADDR_TAC, 8'h05);
        send_word(FUNC_WRITE, ADDR_TIMA, 8'hff);
        // A divider write stores the byte instead of clearing it.
        send_word(FUNC_WRITE, ADDR_DIV, 8'hff);
        // First tick: divider wraps and the timer overflows into the reload.
        send_word(FUNC_TICK, 16'hffff, 8'hff);
        send_word(FUNC_READ, ADDR_IF, 8'h00);
        send_word(FUNC_READ, ADDR_DIV, 8'h00);
        send_word(FUNC_READ, ADDR_TIMA, 8'h00);
        send_word(FUNC_WRITE, 16'h0000, 8'hff);
        send_word(FUNC_READ, 16'hff08, 8'h00);
        send_word(FUNC_READ, 16'h0000, 8'h00);
        send_word(FUNC_RSVD, ADDR_DIV, 8'hff);
        send_word(FUNC_WRITE, ADDR_IF, 8'h00);
        send_word(FUNC_WRITE, ADDR_TAC, 8'h00);
        send_word(FUNC_WRITE, ADDR_IE, 8'h00);

        while (words_sent < WORD_TARGET) begin
            if ($urandom_range(0, 49) == 0)
                no_idle = !no_idle;
            if (!drained && words_sent >= WORD_TARGET / 2) begin
                req_valid <= 1'b0;
                wait_all_results();
                drained = 1'b1;
            end
            if ($urandom_range(0, 99) < 35)
                run_timer_burst();
            else
                send_random_word();
        end
        req_valid <= 1'b0;

        wait_all_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("divider_timer_with_irq_flags_top regression: pass");
        else
            $display("divider_timer_with_irq_flags_top regression: fail");
        $finish;
    end

endmodule
